FILE: design/sorted_table_key_lookup_macros.svh
// Assertion macros shared by the sorted table lookup block.
`ifndef SORTED_TABLE_KEY_LOOKUP_MACROS_SVH
`define SORTED_TABLE_KEY_LOOKUP_MACROS_SVH

// Same-cycle implication, checked on clk and quiet during rst.
`define STKL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("stkl same-cycle check failed");

// Next-cycle implication, checked on clk and quiet during rst.
`define STKL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("stkl next-cycle check failed");

`endif

FILE: design/stkl_pkg.sv
// Package with the entry type, defaults and payload masks of the sorted table lookup.
package stkl_pkg;

  localparam int DEF_TABLE_DEPTH = 1024;
  localparam int DEF_TEXT_CHARS  = 14;
  localparam int ENTRY_W         = 144;

  typedef struct packed {
    logic [47:0]        hi;
    logic [63:0]        lo;
    logic signed [31:0] key;
  } entry_t;

  function automatic logic [63:0] lo_mask(input int tc);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (i < tc) m[i*8 +: 8] = 8'hFF;
    end
    return m;
  endfunction

  function automatic logic [47:0] hi_mask(input int tc);
    logic [47:0] m;
    m = '0;
    for (int i = 0; i < 6; i++) begin
      if (i + 8 < tc) m[i*8 +: 8] = 8'hFF;
    end
    return m;
  endfunction

endpackage

FILE: design/stkl_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module stkl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

FILE: design/sorted_table_key_lookup.sv
// Top level of the sorted table lookup: load, merge sort and binary search sequencer.
//
// The block keeps a table of up to TABLE_DEPTH entries (signed key plus a
// text payload). Items enter on the s_ channel: s_tuser = 0 loads an entry,
// s_tuser = 1 queries a key. A load gives no result; a load into a full table
// is dropped. A query gives one item on the m_ channel with m_tuser = found.
// A query that follows one or more loads first re-sorts the table with a
// top-down merge sort, walked by a small frame stack, using one compare unit
// and a scratch RAM. Each merged element is fetched, compared and placed in
// the scratch RAM, and the merged run is then copied back to the table. The
// search then probes the table RAM, at most floor(log2(n)) + 1 probes. The
// merge and the search both read through the table RAM's single read port.
// s_tready is high only while the sequencer is idle; a finished result waits
// in the output register, and new items are still taken meanwhile, but the
// next query's result holds until the receiver takes the waiting one.
// Reset empties the table and marks it sorted; no clearing pass is needed.
`include "sorted_table_key_lookup_macros.svh"

module sorted_table_key_lookup
  import stkl_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int TEXT_CHARS  = DEF_TEXT_CHARS
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [143:0] s_tdata,   // key[31:0], text_low[95:32], text_high[143:96]
  input  logic         s_tuser,   // cmd: 0 load, 1 query
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,   // position[9:0], text_low_res[73:10],
                                  // text_high_res[121:74], zeros above
  output logic         m_tuser    // found
);

  localparam int IW  = $clog2(TABLE_DEPTH);
  localparam int CW  = IW + 1;
  localparam int SD  = IW + 2;
  localparam int SIW = $clog2(SD);
  localparam int SPW = $clog2(SD + 1);

  typedef enum logic [3:0] {
    IDLE, SRT_VISIT, MRG_RDA, MRG_GETA, MRG_RDB, MRG_GETB, MRG_CMP,
    CPY_RD, CPY_WR, SRCH_PROBE, SRCH_CHK, REPLY
  } state_t;

  state_t state;

  logic [CW-1:0] entry_count;
  logic          is_sorted;

  // Frame stack of the recursive sort: range and how far it has progressed.
  logic [IW-1:0]  stk_lo [SD];
  logic [IW-1:0]  stk_hi [SD];
  logic [1:0]     stk_ph [SD];
  logic [SPW-1:0] sp;

  // Merge registers.
  logic [CW-1:0] a, b, w, i;
  logic [IW-1:0] mlo, mmid, mhi;
  logic          init;
  entry_t        ea, eb;

  // Search registers.
  logic signed [31:0]   qkey;
  logic signed [IW+1:0] l, r;
  logic [IW-1:0]        m;
  logic                 res_found;
  logic [9:0]           res_pos;
  logic [63:0]          res_lo;
  logic [47:0]          res_hi;

  // RAM ports.
  logic          tbl_we, scr_we;
  logic [IW-1:0] tbl_waddr, tbl_raddr, scr_waddr, scr_raddr;
  entry_t        tbl_wdata, tbl_rdata, scr_wdata, scr_rdata;

  logic                 in_fire, load_ok;
  entry_t               in_entry;
  logic [SIW-1:0]       top;
  logic [IW-1:0]        t_lo, t_hi, t_mid;
  logic [1:0]           t_ph;
  logic [IW:0]          mid_sum;
  logic signed [IW+1:0] lr_sum;
  logic [IW-1:0]        probe;
  logic                 a_ok, b_ok, take_a;

  assign s_tready = (state == IDLE);
  assign in_fire  = s_tvalid && s_tready;
  assign load_ok  = in_fire && !s_tuser && (entry_count < CW'(TABLE_DEPTH));

  assign in_entry.key = s_tdata[31:0];
  assign in_entry.lo  = s_tdata[95:32] & lo_mask(TEXT_CHARS);
  assign in_entry.hi  = s_tdata[143:96] & hi_mask(TEXT_CHARS);

  assign top     = SIW'(sp - SPW'(1));
  assign t_lo    = stk_lo[top];
  assign t_hi    = stk_hi[top];
  assign t_ph    = stk_ph[top];
  assign mid_sum = {1'b0, t_lo} + {1'b0, t_hi};
  assign t_mid   = mid_sum[IW:1];

  assign lr_sum = l + r;
  assign probe  = lr_sum[IW:1];

  assign a_ok   = a <= {1'b0, mmid};
  assign b_ok   = b <= {1'b0, mhi};
  assign take_a = a_ok && (!b_ok || (ea.key < eb.key));

  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = entry_count[IW-1:0];
    tbl_wdata = in_entry;
    tbl_raddr = '0;
    scr_we    = 1'b0;
    scr_waddr = w[IW-1:0];
    scr_wdata = take_a ? ea : eb;
    scr_raddr = i[IW-1:0];
    unique case (state)
      IDLE:       tbl_we = load_ok;
      MRG_RDA:    tbl_raddr = a[IW-1:0];
      MRG_RDB:    tbl_raddr = b[IW-1:0];
      MRG_CMP:    scr_we = a_ok || b_ok;
      CPY_WR: begin
        tbl_we    = 1'b1;
        tbl_waddr = mlo + i[IW-1:0];
        tbl_wdata = scr_rdata;
      end
      SRCH_PROBE: tbl_raddr = probe;
      default: ;
    endcase
  end

  stkl_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_table (
    .clk(clk), .we(tbl_we), .waddr(tbl_waddr), .wdata(tbl_wdata),
    .raddr(tbl_raddr), .rdata(tbl_rdata)
  );

  stkl_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_scratch (
    .clk(clk), .we(scr_we), .waddr(scr_waddr), .wdata(scr_wdata),
    .raddr(scr_raddr), .rdata(scr_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= IDLE;
      entry_count <= '0;
      is_sorted   <= 1'b1;
      sp          <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        IDLE: begin
          if (in_fire) begin
            if (!s_tuser) begin
              if (load_ok) begin
                entry_count <= entry_count + CW'(1);
                is_sorted   <= 1'b0;
              end
            end else begin
              qkey      <= s_tdata[31:0];
              l         <= '0;
              r         <= (IW+2)'(entry_count) - (IW+2)'(1);
              res_found <= 1'b0;
              res_pos   <= '0;
              res_lo    <= '0;
              res_hi    <= '0;
              if (!is_sorted) begin
                stk_lo[0] <= '0;
                stk_hi[0] <= IW'(entry_count - CW'(1));
                stk_ph[0] <= 2'd0;
                sp        <= SPW'(1);
                state     <= SRT_VISIT;
              end else begin
                state <= SRCH_PROBE;
              end
            end
          end
        end
        SRT_VISIT: begin
          if (sp == '0) begin
            is_sorted <= 1'b1;
            state     <= SRCH_PROBE;
          end else begin
            unique case (t_ph)
              2'd0: begin
                if (t_lo >= t_hi) begin
                  sp <= sp - SPW'(1);
                end else begin
                  stk_ph[top]            <= 2'd1;
                  stk_lo[sp[SIW-1:0]]    <= t_lo;
                  stk_hi[sp[SIW-1:0]]    <= t_mid;
                  stk_ph[sp[SIW-1:0]]    <= 2'd0;
                  sp                     <= sp + SPW'(1);
                end
              end
              2'd1: begin
                stk_ph[top]         <= 2'd2;
                stk_lo[sp[SIW-1:0]] <= t_mid + IW'(1);
                stk_hi[sp[SIW-1:0]] <= t_hi;
                stk_ph[sp[SIW-1:0]] <= 2'd0;
                sp                  <= sp + SPW'(1);
              end
              default: begin
                // Both halves are sorted: merge them, then pop after copy-back.
                a     <= {1'b0, t_lo};
                b     <= {1'b0, t_mid} + CW'(1);
                mlo   <= t_lo;
                mmid  <= t_mid;
                mhi   <= t_hi;
                w     <= '0;
                init  <= 1'b1;
                state <= MRG_RDA;
              end
            endcase
          end
        end
        MRG_RDA:  state <= MRG_GETA;
        MRG_GETA: begin
          ea    <= tbl_rdata;
          state <= init ? MRG_RDB : MRG_CMP;
        end
        MRG_RDB:  state <= MRG_GETB;
        MRG_GETB: begin
          eb    <= tbl_rdata;
          init  <= 1'b0;
          state <= MRG_CMP;
        end
        MRG_CMP: begin
          if (!a_ok && !b_ok) begin
            i     <= '0;
            state <= CPY_RD;
          end else begin
            w <= w + CW'(1);
            if (take_a) begin
              a     <= a + CW'(1);
              state <= MRG_RDA;
            end else begin
              b     <= b + CW'(1);
              state <= MRG_RDB;
            end
          end
        end
        CPY_RD: state <= CPY_WR;
        CPY_WR: begin
          i <= i + CW'(1);
          if (i + CW'(1) == w) begin
            sp    <= sp - SPW'(1);
            state <= SRT_VISIT;
          end else begin
            state <= CPY_RD;
          end
        end
        SRCH_PROBE: begin
          if (l > r) begin
            state <= REPLY;
          end else begin
            m     <= probe;
            state <= SRCH_CHK;
          end
        end
        SRCH_CHK: begin
          if (tbl_rdata.key == qkey) begin
            res_found <= 1'b1;
            res_pos   <= 10'(m);
            res_lo    <= tbl_rdata.lo;
            res_hi    <= tbl_rdata.hi;
            state     <= REPLY;
          end else begin
            if (tbl_rdata.key < qkey) l <= (IW+2)'(m) + (IW+2)'(1);
            else                      r <= (IW+2)'(m) - (IW+2)'(1);
            state <= SRCH_PROBE;
          end
        end
        REPLY: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= res_found;
            m_tdata  <= {6'd0, res_hi, res_lo, res_pos};
            state    <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  // A result that reports no match carries all-zero data.
  `STKL_ASSERT_NOW(a_miss_zero, m_tvalid && !m_tuser, m_tdata == '0)
  // A load into a table with room grows the count by exactly one.
  `STKL_ASSERT_NEXT(a_load_grows, load_ok, entry_count == $past(entry_count) + CW'(1))
  // A query on an unsorted table starts the sort sequencer.
  `STKL_ASSERT_NEXT(a_sort_starts, in_fire && s_tuser && !is_sorted, state == SRT_VISIT)
  // The count never passes the table size.
  `STKL_ASSERT_NOW(a_count_cap, 1'b1, entry_count <= CW'(TABLE_DEPTH))

endmodule
